>>> hdl/aabbct_pkg.sv
// Shared types, codes and defaults for the box collision table.
`default_nettype none
package aabbct_pkg;

  localparam int MAX_ITEMS_DEF = 32;

  localparam int COORD_W = 16;
  localparam int ID_W    = 16;
  localparam int ENTRY_W = 4 * COORD_W + ID_W;

  localparam logic [1:0] OP_ADD    = 2'd0;
  localparam logic [1:0] OP_REMOVE = 2'd1;
  localparam logic [1:0] OP_QUERY  = 2'd2;

  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_FULL      = 2'd1;
  localparam logic [1:0] ST_NOT_FOUND = 2'd2;

  typedef enum logic [2:0] {
    S_IDLE,
    S_EXEC,
    S_SCAN,
    S_SHIFT,
    S_PUB
  } state_t;

  typedef struct packed {
    logic       capture;
    logic       append;
    logic       scan_start;
    logic       scan_step;
    logic       shift_start;
    logic       shift_step;
    logic       shrink;
    logic       set_res;
    logic       res_hit;
    logic [1:0] res_status;
    logic       publish;
  } cmd_t;

  typedef struct packed {
    logic [1:0] op;
    logic       full;
    logic       match_id;
    logic       match_q;
    logic       walk_done;
    logic       out_busy;
  } sts_t;

endpackage
`default_nettype wire

>>> hdl/aabb_collision_table.sv
// Top level of the box collision table: stream ports, controller and datapath.
//
// channel  | dir | payload
// s_axis   | in  | tuser: opcode; tdata: item_id, box edges, skip_own
// m_axis   | out | tdata: hit, hit_id, status
//
// An add runs through the execute and publish states; a query or a remove walks the
// entries one entry a cycle, read through a registered port beside a separate write
// port, and a remove then shifts later entries down. One item is in work at a time. A
// result waits in an output register; a stalled output holds the next result back
// before publication. Reset empties the table; entry contents are not cleared.
`default_nettype none
module aabb_collision_table
  import aabbct_pkg::*;
#(
  parameter int MAX_ITEMS = MAX_ITEMS_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  // [15:0] item_id, [31:16] box_left, [47:32] box_top, [63:48] box_right,
  // [79:64] box_bottom, [80] skip_own, [87:81] zero
  input  wire logic [87:0] s_axis_tdata,
  // [1:0] opcode
  input  wire logic [1:0]  s_axis_tuser,
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  // [0] hit, [16:1] hit_id, [18:17] status, [23:19] zero
  output logic [23:0]      m_axis_tdata
);

  cmd_t            cmd;
  sts_t            sts;
  logic            out_hit;
  logic [ID_W-1:0] out_hit_id;
  logic [1:0]      out_status;

  aabbct_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_axis_tvalid),
    .in_ready (s_axis_tready),
    .sts      (sts),
    .cmd      (cmd)
  );

  aabbct_dp #(
    .MAX_ITEMS (MAX_ITEMS)
  ) u_dp (
    .clk        (clk),
    .rst        (rst),
    .cmd        (cmd),
    .sts        (sts),
    .in_op      (s_axis_tuser),
    .in_id      (s_axis_tdata[15:0]),
    .in_left    (s_axis_tdata[31:16]),
    .in_top     (s_axis_tdata[47:32]),
    .in_right   (s_axis_tdata[63:48]),
    .in_bottom  (s_axis_tdata[79:64]),
    .in_skip    (s_axis_tdata[80]),
    .out_ready  (m_axis_tready),
    .out_valid  (m_axis_tvalid),
    .out_hit    (out_hit),
    .out_hit_id (out_hit_id),
    .out_status (out_status)
  );

  assign m_axis_tdata = {5'b0, out_status, out_hit_id, out_hit};

endmodule
`default_nettype wire

>>> hdl/aabbct_dp.sv
// Datapath of the box collision table: entry memory, walk pointers, compare and result registers.
`default_nettype none
module aabbct_dp
  import aabbct_pkg::*;
#(
  parameter int MAX_ITEMS = MAX_ITEMS_DEF
) (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire cmd_t                cmd,
  output sts_t                     sts,
  input  wire logic [1:0]          in_op,
  input  wire logic [ID_W-1:0]     in_id,
  input  wire logic [COORD_W-1:0]  in_left,
  input  wire logic [COORD_W-1:0]  in_top,
  input  wire logic [COORD_W-1:0]  in_right,
  input  wire logic [COORD_W-1:0]  in_bottom,
  input  wire logic                in_skip,
  input  wire logic                out_ready,
  output logic                     out_valid,
  output logic                     out_hit,
  output logic [ID_W-1:0]          out_hit_id,
  output logic [1:0]               out_status
);

  localparam int AW = (MAX_ITEMS > 1) ? $clog2(MAX_ITEMS) : 1;
  localparam int IW = $clog2(MAX_ITEMS + 1);

  logic [ENTRY_W-1:0] mem [MAX_ITEMS];
  logic [ENTRY_W-1:0] rdata;
  logic [ENTRY_W-1:0] wdata;
  logic [AW-1:0]      waddr;
  logic               we;

  logic [1:0]         q_op;
  logic [ID_W-1:0]    q_id;
  logic signed [COORD_W-1:0] q_left, q_top, q_right, q_bottom;
  logic               q_skip;

  logic [IW-1:0]      count;
  logic [IW-1:0]      rd_ptr;
  logic [AW-1:0]      pend_idx;
  logic               pend_valid;

  logic               res_hit;
  logic [ID_W-1:0]    res_id;
  logic [1:0]         res_status;

  logic signed [COORD_W-1:0] e_left, e_top, e_right, e_bottom;
  logic [ID_W-1:0]    e_id;
  logic signed [COORD_W-1:0] lo_x, hi_x, lo_y, hi_y;
  logic               overlap;
  logic               id_eq;
  logic               step;

  assign e_left   = rdata[COORD_W-1:0];
  assign e_top    = rdata[2*COORD_W-1:COORD_W];
  assign e_right  = rdata[3*COORD_W-1:2*COORD_W];
  assign e_bottom = rdata[4*COORD_W-1:3*COORD_W];
  assign e_id     = rdata[ENTRY_W-1:4*COORD_W];

  always_comb begin
    lo_x = (q_left > e_left) ? q_left : e_left;
    hi_x = (q_right < e_right) ? q_right : e_right;
    lo_y = (q_top > e_top) ? q_top : e_top;
    hi_y = (q_bottom < e_bottom) ? q_bottom : e_bottom;
    overlap = (lo_x <= hi_x) && (lo_y <= hi_y);
    id_eq = (e_id == q_id);
  end

  assign step = cmd.scan_step || cmd.shift_step;

  always_comb begin
    we    = 1'b0;
    waddr = count[AW-1:0];
    wdata = {q_id, q_bottom, q_right, q_top, q_left};
    if (cmd.append) begin
      we = 1'b1;
    end else if (cmd.shift_step && pend_valid) begin
      we    = 1'b1;
      waddr = pend_idx - AW'(1);
      wdata = rdata;
    end
  end

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[rd_ptr[AW-1:0]];
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      q_op     <= in_op;
      q_id     <= in_id;
      q_left   <= in_left;
      q_top    <= in_top;
      q_right  <= in_right;
      q_bottom <= in_bottom;
      q_skip   <= in_skip;
    end
    if (cmd.set_res) begin
      res_hit    <= cmd.res_hit;
      res_id     <= cmd.res_hit ? e_id : '0;
      res_status <= cmd.res_status;
    end
    if (cmd.publish) begin
      out_hit    <= res_hit;
      out_hit_id <= res_id;
      out_status <= res_status;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count      <= '0;
      rd_ptr     <= '0;
      pend_idx   <= '0;
      pend_valid <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      if (cmd.append) begin
        count <= count + IW'(1);
      end else if (cmd.shrink) begin
        count <= count - IW'(1);
      end
      if (cmd.scan_start) begin
        rd_ptr     <= '0;
        pend_valid <= 1'b0;
      end else if (cmd.shift_start) begin
        rd_ptr     <= IW'(pend_idx) + IW'(1);
        pend_valid <= 1'b0;
      end else if (step) begin
        if (rd_ptr < count) begin
          pend_valid <= 1'b1;
          pend_idx   <= rd_ptr[AW-1:0];
          rd_ptr     <= rd_ptr + IW'(1);
        end else begin
          pend_valid <= 1'b0;
        end
      end
      if (cmd.publish) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_comb begin
    sts.op        = q_op;
    sts.full      = (count == IW'(MAX_ITEMS));
    sts.match_id  = pend_valid && id_eq;
    sts.match_q   = pend_valid && overlap && !(q_skip && id_eq);
    sts.walk_done = !pend_valid && (rd_ptr >= count);
    sts.out_busy  = out_valid && !out_ready;
  end

endmodule
`default_nettype wire

>>> hdl/aabbct_ctrl.sv
// Controller state machine of the box collision table.
`default_nettype none
module aabbct_ctrl
  import aabbct_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic in_valid,
  output logic      in_ready,
  input  wire sts_t sts,
  output cmd_t      cmd
);

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    in_ready   = 1'b0;
    unique case (state)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.capture = 1'b1;
          state_next  = S_EXEC;
        end
      end
      S_EXEC: begin
        priority if (sts.op == OP_ADD) begin
          cmd.set_res = 1'b1;
          if (sts.full) begin
            cmd.res_status = ST_FULL;
          end else begin
            cmd.append     = 1'b1;
            cmd.res_status = ST_OK;
          end
          state_next = S_PUB;
        end else if (sts.op == OP_REMOVE || sts.op == OP_QUERY) begin
          cmd.scan_start = 1'b1;
          state_next     = S_SCAN;
        end else begin
          cmd.set_res = 1'b1;
          state_next  = S_PUB;
        end
      end
      S_SCAN: begin
        if (sts.op == OP_REMOVE) begin
          priority if (sts.match_id) begin
            cmd.shift_start = 1'b1;
            state_next      = S_SHIFT;
          end else if (sts.walk_done) begin
            cmd.set_res    = 1'b1;
            cmd.res_status = ST_NOT_FOUND;
            state_next     = S_PUB;
          end else begin
            cmd.scan_step = 1'b1;
          end
        end else begin
          priority if (sts.match_q) begin
            cmd.set_res = 1'b1;
            cmd.res_hit = 1'b1;
            state_next  = S_PUB;
          end else if (sts.walk_done) begin
            cmd.set_res = 1'b1;
            state_next  = S_PUB;
          end else begin
            cmd.scan_step = 1'b1;
          end
        end
      end
      S_SHIFT: begin
        if (sts.walk_done) begin
          cmd.shrink     = 1'b1;
          cmd.set_res    = 1'b1;
          cmd.res_status = ST_OK;
          state_next     = S_PUB;
        end else begin
          cmd.shift_step = 1'b1;
        end
      end
      S_PUB: begin
        if (!sts.out_busy) begin
          cmd.publish = 1'b1;
          state_next  = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule
`default_nettype wire

>>> bench/aabb_collision_table_tb.sv
// Testbench for the box collision table: directed and random items checked against a predictor.
`default_nettype none
module aabb_collision_table_tb;
  import aabbct_pkg::*;

  localparam logic [1:0] OP_UNUSED = 2'd3;
  localparam int ITEM_TARGET = 1700;

  typedef struct {
    logic [1:0]  op;
    logic [15:0] id;
    logic [15:0] left;
    logic [15:0] top;
    logic [15:0] right;
    logic [15:0] bottom;
    logic        skip;
  } item_t;

  typedef struct {
    logic        hit;
    logic [15:0] hit_id;
    logic [1:0]  status;
  } outcome_t;

  typedef struct {
    item_t    it;
    bit       typed;
    outcome_t want;
  } row_t;

  typedef enum int {MODE_FILL, MODE_MIXED, MODE_DRAIN} mode_t;

  logic        clk = 1'b0;
  logic        rst;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [87:0] s_axis_tdata;
  logic [1:0]  s_axis_tuser;
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [23:0] m_axis_tdata;

  logic signed [15:0] tbl_left[MAX_ITEMS_DEF];
  logic signed [15:0] tbl_top[MAX_ITEMS_DEF];
  logic signed [15:0] tbl_right[MAX_ITEMS_DEF];
  logic signed [15:0] tbl_bottom[MAX_ITEMS_DEF];
  logic [15:0]        tbl_id[MAX_ITEMS_DEF];
  int                 tbl_count = 0;

  outcome_t pending_results[$];
  row_t     directed_rows[$];
  int       error_count = 0;
  bit       steady = 1'b0;

  aabb_collision_table u_top (
    .clk          (clk),
    .rst          (rst),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  function automatic outcome_t table_step(item_t q);
    outcome_t res;
    logic signed [15:0] ql, qt, qr, qb, lo_x, hi_x, lo_y, hi_y;
    int found, i, k;
    res = '{1'b0, 16'd0, ST_OK};
    ql = q.left;
    qt = q.top;
    qr = q.right;
    qb = q.bottom;
    case (q.op)
      OP_ADD: begin
        if (tbl_count >= MAX_ITEMS_DEF) begin
          res.status = ST_FULL;
        end else begin
          tbl_left[tbl_count] = ql;
          tbl_top[tbl_count] = qt;
          tbl_right[tbl_count] = qr;
          tbl_bottom[tbl_count] = qb;
          tbl_id[tbl_count] = q.id;
          tbl_count++;
        end
      end
      OP_REMOVE: begin
        found = -1;
        for (i = 0; i < tbl_count; i++)
          if (found < 0 && tbl_id[i] == q.id) found = i;
        if (found < 0) begin
          res.status = ST_NOT_FOUND;
        end else begin
          for (k = found; k + 1 < tbl_count; k++) begin
            tbl_left[k] = tbl_left[k + 1];
            tbl_top[k] = tbl_top[k + 1];
            tbl_right[k] = tbl_right[k + 1];
            tbl_bottom[k] = tbl_bottom[k + 1];
            tbl_id[k] = tbl_id[k + 1];
          end
          tbl_count--;
        end
      end
      OP_QUERY: begin
        for (i = 0; i < tbl_count; i++) begin
          if (!res.hit && !(q.skip && tbl_id[i] == q.id)) begin
            lo_x = (ql > tbl_left[i]) ? ql : tbl_left[i];
            hi_x = (qr < tbl_right[i]) ? qr : tbl_right[i];
            lo_y = (qt > tbl_top[i]) ? qt : tbl_top[i];
            hi_y = (qb < tbl_bottom[i]) ? qb : tbl_bottom[i];
            if (lo_x <= hi_x && lo_y <= hi_y) begin
              res.hit = 1'b1;
              res.hit_id = tbl_id[i];
            end
          end
        end
      end
      default: ;
    endcase
    return res;
  endfunction

  function automatic item_t draw_item(mode_t mode);
    item_t q;
    int pick, base, span;
    pick = $urandom_range(0, 99);
    case (mode)
      MODE_FILL:
        q.op = pick < 70 ? OP_ADD : pick < 90 ? OP_QUERY : pick < 98 ? OP_REMOVE : OP_UNUSED;
      MODE_MIXED:
        q.op = pick < 35 ? OP_ADD : pick < 75 ? OP_QUERY : pick < 97 ? OP_REMOVE : OP_UNUSED;
      default:
        q.op = pick < 10 ? OP_ADD : pick < 35 ? OP_QUERY : pick < 98 ? OP_REMOVE : OP_UNUSED;
    endcase
    if (tbl_count > 0 && $urandom_range(0, 3) != 0)
      q.id = tbl_id[$urandom_range(0, tbl_count - 1)];
    else if ($urandom_range(0, 4) != 0)
      q.id = 16'($urandom_range(0, 15));
    else
      q.id = 16'($urandom());
    if ($urandom_range(0, 6) == 0) begin
      q.left = 16'($urandom());
      q.top = 16'($urandom());
      q.right = 16'($urandom());
      q.bottom = 16'($urandom());
    end else begin
      base = $urandom_range(0, 200) - 100;
      span = $urandom_range(0, 40);
      q.left = 16'(base);
      q.right = 16'(base + span);
      base = $urandom_range(0, 200) - 100;
      span = $urandom_range(0, 40);
      q.top = 16'(base);
      q.bottom = 16'(base + span);
    end
    q.skip = 1'($urandom_range(0, 1));
    return q;
  endfunction

  task automatic plan_row(input logic [1:0] op, input logic [15:0] id,
                          input logic [15:0] l, input logic [15:0] t,
                          input logic [15:0] r, input logic [15:0] b,
                          input logic skip, input bit typed,
                          input logic hit, input logic [15:0] hit_id,
                          input logic [1:0] status);
    row_t row;
    row.it = '{op, id, l, t, r, b, skip};
    row.typed = typed;
    row.want = '{hit, hit_id, status};
    directed_rows.insert(directed_rows.size(), row);
  endtask

  task automatic send_item(input item_t q, input bit typed, input outcome_t want);
    int gap;
    outcome_t got;
    gap = steady ? 0 : $urandom_range(0, 3);
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= {7'd0, q.skip, q.bottom, q.right, q.top, q.left, q.id};
    s_axis_tuser <= q.op;
    do @(posedge clk); while (!s_axis_tready);
    got = table_step(q);
    pending_results.insert(pending_results.size(), typed ? want : got);
  endtask

  initial begin : result_sink
    int stall;
    m_axis_tready <= 1'b0;
    forever begin
      stall = steady ? 0 : $urandom_range(0, 3);
      if (stall > 0) begin
        m_axis_tready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      m_axis_tready <= 1'b1;
      do @(posedge clk); while (m_axis_tvalid !== 1'b1);
    end
  end

  always @(posedge clk) begin : check_results
    outcome_t want;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      if (pending_results.size() == 0) begin
        $display("%0t: result with none expected, expected none, actual %h",
                 $time, m_axis_tdata);
        error_count++;
      end else begin
        want = pending_results.pop_front();
        if (m_axis_tdata[0] !== want.hit) begin
          $display("%0t: hit expected %0d actual %0d", $time, want.hit, m_axis_tdata[0]);
          error_count++;
        end
        if (m_axis_tdata[16:1] !== want.hit_id) begin
          $display("%0t: hit_id expected %h actual %h", $time, want.hit_id,
                   m_axis_tdata[16:1]);
          error_count++;
        end
        if (m_axis_tdata[18:17] !== want.status) begin
          $display("%0t: status expected %0d actual %0d", $time, want.status,
                   m_axis_tdata[18:17]);
          error_count++;
        end
      end
    end
  end

  initial begin : stimulus
    outcome_t none_out;
    mode_t mode;
    int sent, seg_len;
    none_out = '{1'b0, 16'd0, ST_OK};
    s_axis_tvalid <= 1'b0;
    s_axis_tdata <= '0;
    s_axis_tuser <= OP_ADD;
    rst <= 1'b1;
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    // op, id, left, top, right, bottom, skip, typed, hit, hit_id, status
    plan_row(OP_QUERY, 16'h0000, 16'h8000, 16'h8000, 16'h7FFF, 16'h7FFF, 1'b0,
             1'b1, 1'b0, 16'h0000, ST_OK);
    plan_row(OP_REMOVE, 16'h0005, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 1'b0,
             1'b1, 1'b0, 16'h0000, ST_NOT_FOUND);
    plan_row(OP_UNUSED, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b1,
             1'b1, 1'b0, 16'h0000, ST_OK);
    plan_row(OP_ADD, 16'hFFFF, 16'h8000, 16'h8000, 16'h8000, 16'h8000, 1'b0,
             1'b1, 1'b0, 16'h0000, ST_OK);
    plan_row(OP_ADD, 16'h0000, 16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF, 1'b1,
             1'b1, 1'b0, 16'h0000, ST_OK);
    plan_row(OP_ADD, 16'h1234, -16'sd10, -16'sd10, 16'sd10, 16'sd10, 1'b0,
             1'b1, 1'b0, 16'h0000, ST_OK);
    // duplicate id, then an inverted box
    plan_row(OP_ADD, 16'h1234, 16'sd100, 16'sd100, 16'sd200, 16'sd200, 1'b0,
             1'b1, 1'b0, 16'h0000, ST_OK);
    plan_row(OP_ADD, 16'h0007, 16'sd50, 16'sd50, -16'sd50, -16'sd50, 1'b0,
             1'b1, 1'b0, 16'h0000, ST_OK);
    plan_row(OP_QUERY, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 1'b0,
             1'b0, 1'b0, 16'h0000, ST_OK);
    plan_row(OP_QUERY, 16'h1234, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 1'b1,
             1'b0, 1'b0, 16'h0000, ST_OK);
    // touching edges count as overlap
    plan_row(OP_QUERY, 16'h1234, 16'sd200, 16'sd200, 16'sd300, 16'sd300, 1'b0,
             1'b0, 1'b0, 16'h0000, ST_OK);
    plan_row(OP_QUERY, 16'h0001, 16'h8000, 16'h8000, 16'h8000, 16'h8000, 1'b0,
             1'b0, 1'b0, 16'h0000, ST_OK);
    plan_row(OP_QUERY, 16'h0001, 16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF, 1'b0,
             1'b0, 1'b0, 16'h0000, ST_OK);
    plan_row(OP_QUERY, 16'h0000, 16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF, 1'b1,
             1'b0, 1'b0, 16'h0000, ST_OK);
    plan_row(OP_QUERY, 16'h0000, 16'sd10, 16'sd10, -16'sd10, -16'sd10, 1'b0,
             1'b0, 1'b0, 16'h0000, ST_OK);
    plan_row(OP_REMOVE, 16'h1234, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 1'b0,
             1'b1, 1'b0, 16'h0000, ST_OK);
    plan_row(OP_QUERY, 16'h0000, -16'sd5, -16'sd5, 16'sd150, 16'sd150, 1'b0,
             1'b0, 1'b0, 16'h0000, ST_OK);
    plan_row(OP_REMOVE, 16'hFFFF, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 1'b0,
             1'b1, 1'b0, 16'h0000, ST_OK);
    plan_row(OP_QUERY, 16'hFFFF, 16'h8000, 16'h8000, 16'h7FFF, 16'h7FFF, 1'b1,
             1'b0, 1'b0, 16'h0000, ST_OK);
    plan_row(OP_REMOVE, 16'hFFFF, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 1'b0,
             1'b1, 1'b0, 16'h0000, ST_NOT_FOUND);
    plan_row(OP_ADD, 16'h8000, 16'h8000, 16'h7FFF, 16'h0000, 16'hFFFF, 1'b1,
             1'b1, 1'b0, 16'h0000, ST_OK);
    plan_row(OP_QUERY, 16'h8000, 16'h8000, 16'h8000, 16'h7FFF, 16'h7FFF, 1'b1,
             1'b0, 1'b0, 16'h0000, ST_OK);
    plan_row(OP_QUERY, 16'h0000, 16'h8000, 16'h8000, 16'h7FFF, 16'h7FFF, 1'b1,
             1'b0, 1'b0, 16'h0000, ST_OK);

    foreach (directed_rows[i])
      send_item(directed_rows[i].it, directed_rows[i].typed, directed_rows[i].want);

    sent = 0;
    while (sent < ITEM_TARGET) begin
      if (tbl_count >= 28) mode = $urandom_range(0, 1) ? MODE_DRAIN : MODE_MIXED;
      else if (tbl_count <= 4) mode = MODE_FILL;
      else mode = mode_t'($urandom_range(0, 2));
      steady = ($urandom_range(0, 3) == 0);
      // hold off until every outstanding result is back
      if (sent == 0 || $urandom_range(0, 2) == 0) begin
        s_axis_tvalid <= 1'b0;
        do @(posedge clk); while (pending_results.size() != 0);
      end
      seg_len = $urandom_range(20, 80);
      repeat (seg_len) begin
        send_item(draw_item(mode), 1'b0, none_out);
        sent++;
      end
    end

    s_axis_tvalid <= 1'b0;
    do @(posedge clk); while (pending_results.size() != 0);
    repeat (MAX_ITEMS_DEF + 8) @(posedge clk);
    if (error_count == 0)
      $display("status: pass");
    else
      $display("status: fail");
    $finish;
  end

  initial begin : watchdog
    #2000000;
    $display("status: fail");
    $finish;
  end

endmodule
`default_nettype wire
